// ===== rtl/keyframe_track_sampler_unit_macros.svh =====
// Assertion macros used by the checker file of the sampler.
`ifndef KEYFRAME_TRACK_SAMPLER_UNIT_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/kts_pkg.sv =====
package kts_pkg;

   // Default size of the keyframe table.
   localparam int MAX_KEYS_DEF = 64;

   // Field and register widths.
   localparam int VAL_W       = 32;
   localparam int KEY_COUNT_W = 7;
   localparam int SPEED_W     = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int FRAC_W      = 17;
   localparam int FRAC_STEPS  = 17;
   localparam int STEP_W      = 5;

   // Register reset values.
   localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 7'd2;
   localparam logic [SPEED_W-1:0]     SPEED_RESET     = 16'd256;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED     = 1'b1;

   // Transaction function codes.
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   // One keyframe as stored in the key memory.
   typedef struct packed {
      logic [VAL_W-1:0] stamp;
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
      logic [VAL_W-1:0] z;
   } key_type;

   // Value component under interpolation.
   typedef enum logic [1:0] {
      COMP_X,
      COMP_Y,
      COMP_Z
   } comp_type;

   // Request to the fraction divider.
   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] dividend;
      logic [VAL_W-1:0] divisor;
   } div_req_type;

   // Selects one value component of a keyframe.
   function automatic logic [VAL_W-1:0] key_comp(key_type k, comp_type c);
      logic [VAL_W-1:0] v;
      case (c)
         COMP_X:  v = k.x;
         COMP_Y:  v = k.y;
         COMP_Z:  v = k.z;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/kts_ram.sv =====
module kts_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kts_frac_div.sv =====
module kts_frac_div (
   input  logic                      clock,
   input  logic                      reset,
   input  kts_pkg::div_req_type      req,
   output logic                      done,
   output logic [kts_pkg::FRAC_W-1:0] quotient
);

   import kts_pkg::*;

   logic                active_ff;
   logic                first_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [VAL_W:0]      rem_ff;
   logic [VAL_W-1:0]    den_ff;
   logic [FRAC_W-1:0]   quo_ff;
   logic [VAL_W:0]      shifted;
   logic                fits;

   // The dividend never exceeds the divisor, so the first step needs no shift
   // and the partial remainder always stays below twice the divisor.
   always_comb begin
      shifted = first_ff ? rem_ff : {rem_ff[VAL_W-1:0], 1'b0};
      fits    = shifted >= {1'b0, den_ff};
   end

   // Restoring division, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         first_ff  <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            active_ff <= 1'b1;
            first_ff  <= 1'b1;
            step_ff   <= '0;
            rem_ff    <= {1'b0, req.dividend};
            den_ff    <= req.divisor;
            quo_ff    <= '0;
         end else if (active_ff) begin
            first_ff <= 1'b0;
            rem_ff   <= fits ? (shifted - {1'b0, den_ff}) : shifted;
            quo_ff   <= {quo_ff[FRAC_W-2:0], fits};
            step_ff  <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(FRAC_STEPS - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/keyframe_track_sampler_unit.sv =====
// Channel        Ports                             Handshake
// -------------  --------------------------------  ------------------------------
// request        req_func .. req_delta_time        start high while busy is low
// response       rsp_sample_x .. rsp_wrapped       rsp_valid strobe, one cycle
// configuration  csr_index, csr_wdata             csr_we, written at once
//
// A load transaction completes at its accepting edge and leaves busy low.
// An advance holds busy while it scans the keys (1 to key_count - 1, plus 2
// on a wrap), as the key memory reads one key per cycle; the serial divider
// runs unless the fraction is zero. The response strobe comes in the first
// cycle with busy low. Reset is synchronous and clears time and registers, not
// the key memory. The receiver cannot stall.
module keyframe_track_sampler_unit #(
   parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [5:0]                        req_key_index,
   input  logic [kts_pkg::VAL_W-1:0]         req_key_time,
   input  logic signed [kts_pkg::VAL_W-1:0]  req_value_x,
   input  logic signed [kts_pkg::VAL_W-1:0]  req_value_y,
   input  logic signed [kts_pkg::VAL_W-1:0]  req_value_z,
   input  logic [15:0]                       req_delta_time,
   output logic                              rsp_valid,
   output logic signed [kts_pkg::VAL_W-1:0]  rsp_sample_x,
   output logic signed [kts_pkg::VAL_W-1:0]  rsp_sample_y,
   output logic signed [kts_pkg::VAL_W-1:0]  rsp_sample_z,
   output logic [kts_pkg::VAL_W-1:0]         rsp_time_now,
   output logic                              rsp_wrapped,
   input  logic                              csr_we,
   input  logic [kts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import kts_pkg::*;

   localparam int AW = $clog2(MAX_KEYS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INC,
      S_SUM,
      S_SCAN,
      S_RW0,
      S_RW1,
      S_PREP,
      S_DWAIT,
      S_DIFF,
      S_PROD,
      S_ACC
   } state_type;

   state_type              state_ff;
   logic [KEY_COUNT_W-1:0] key_count_ff;
   logic [SPEED_W-1:0]     speed_ff;
   logic [VAL_W-1:0]       anim_ff;
   logic [15:0]            delta_ff;
   logic [23:0]            incr_ff;
   logic [AW-1:0]          ptr_ff;
   key_type                prev_ff;
   key_type                cur_ff;
   logic                   wrapped_ff;
   logic [FRAC_W-1:0]      frac_ff;
   comp_type               comp_ff;
   logic signed [VAL_W:0]  diff_ff;
   logic signed [50:0]     prod_ff;
   logic                   rsp_valid_ff;
   logic [VAL_W-1:0]       rsp_x_ff;
   logic [VAL_W-1:0]       rsp_y_ff;
   logic [VAL_W-1:0]       rsp_z_ff;
   logic [VAL_W-1:0]       rsp_time_ff;
   logic                   rsp_wrapped_ff;

   logic                   accept;
   logic                   load_ok;
   logic [31:0]            idx_ext;
   logic [31:0]            count_ext;
   logic [31:0]            last_ext;
   logic [AW-1:0]          last_idx;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   key_type                wr_key;
   key_type                rd_key;
   logic [$bits(key_type)-1:0] rd_data;
   logic [31:0]            scaled;
   logic [VAL_W:0]         sum_in;
   logic                   hit;
   logic                   zero_frac;
   div_req_type            div_req;
   logic                   div_done;
   logic [FRAC_W-1:0]      div_quot;
   logic [VAL_W-1:0]       v0;
   logic [VAL_W-1:0]       v1;
   logic [VAL_W-1:0]       lerp_in;
   logic signed [FRAC_W:0] frac_s;

   assign accept = start && !busy;
   assign busy   = state_ff != S_IDLE;

   // Key loads go straight into the memory; out-of-range slots are dropped.
   always_comb begin
      idx_ext      = 32'(req_key_index);
      load_ok      = idx_ext < 32'(MAX_KEYS);
      wr_addr      = idx_ext[AW-1:0];
      wr_key.stamp = req_key_time;
      wr_key.x     = req_value_x;
      wr_key.y     = req_value_y;
      wr_key.z     = req_value_z;
   end

   // Last key index in use, with the count clamped to the table.
   always_comb begin
      count_ext = 32'(key_count_ff);
      if (count_ext < 32'd2) begin
         last_ext = 32'd1;
      end else if (count_ext > 32'(MAX_KEYS)) begin
         last_ext = 32'(MAX_KEYS - 1);
      end else begin
         last_ext = count_ext - 32'd1;
      end
      last_idx = last_ext[AW-1:0];
   end

   // Scan compare on the key that arrives from the memory this cycle.
   assign rd_key = key_type'(rd_data);
   assign hit    = anim_ff <= rd_key.stamp;

   // Read address: entry 0 first, then one key per cycle during the scan.
   always_comb begin
      case (state_ff)
         S_INC:   rd_addr = '0;
         S_SUM:   rd_addr = AW'(1);
         S_SCAN:  rd_addr = (!hit && ptr_ff == last_idx) ? '0 : ptr_ff + AW'(1);
         S_RW0:   rd_addr = AW'(1);
         default: rd_addr = '0;
      endcase
   end

   kts_ram #(
      .WIDTH($bits(key_type)),
      .DEPTH(MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (accept && req_func == FUNC_LOAD && load_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_key),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Time increment and saturating sum.
   assign scaled = 32'(delta_ff) * 32'(speed_ff);
   assign sum_in = {1'b0, anim_ff} + 33'(incr_ff);

   // Fraction setup: a degenerate segment or a time before its start gives zero.
   always_comb begin
      zero_frac        = (cur_ff.stamp <= prev_ff.stamp) || (anim_ff < prev_ff.stamp);
      div_req.start    = (state_ff == S_PREP) && !zero_frac;
      div_req.dividend = anim_ff - prev_ff.stamp;
      div_req.divisor  = cur_ff.stamp - prev_ff.stamp;
   end

   kts_frac_div u_frac_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Interpolation of one component: difference, product, then floor shift and add.
   always_comb begin
      v0      = key_comp(prev_ff, comp_ff);
      v1      = key_comp(cur_ff, comp_ff);
      frac_s  = $signed({1'b0, frac_ff});
      lerp_in = v0 + prod_ff[47:16];
   end

   // Sequencer with its registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         key_count_ff   <= KEY_COUNT_RESET;
         speed_ff       <= SPEED_RESET;
         anim_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         wrapped_ff     <= 1'b0;
         comp_ff        <= COMP_X;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_COUNT: key_count_ff <= csr_wdata[KEY_COUNT_W-1:0];
               CSR_SPEED:     speed_ff     <= csr_wdata[SPEED_W-1:0];
               default:       ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && req_func == FUNC_ADVANCE) begin
                  delta_ff <= req_delta_time;
                  state_ff <= S_INC;
               end
            end
            S_INC: begin
               incr_ff    <= scaled[31:8];
               wrapped_ff <= 1'b0;
               state_ff   <= S_SUM;
            end
            S_SUM: begin
               anim_ff  <= sum_in[VAL_W] ? '1 : sum_in[VAL_W-1:0];
               prev_ff  <= rd_key;
               ptr_ff   <= AW'(1);
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (hit) begin
                  cur_ff   <= rd_key;
                  state_ff <= S_PREP;
               end else if (ptr_ff == last_idx) begin
                  anim_ff    <= '0;
                  wrapped_ff <= 1'b1;
                  state_ff   <= S_RW0;
               end else begin
                  prev_ff <= rd_key;
                  ptr_ff  <= ptr_ff + AW'(1);
               end
            end
            S_RW0: begin
               prev_ff  <= rd_key;
               state_ff <= S_RW1;
            end
            S_RW1: begin
               cur_ff   <= rd_key;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               comp_ff <= COMP_X;
               if (zero_frac) begin
                  frac_ff  <= '0;
                  state_ff <= S_DIFF;
               end else begin
                  state_ff <= S_DWAIT;
               end
            end
            S_DWAIT: begin
               if (div_done) begin
                  frac_ff  <= div_quot;
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: begin
               diff_ff  <= $signed({v1[VAL_W-1], v1}) - $signed({v0[VAL_W-1], v0});
               state_ff <= S_PROD;
            end
            S_PROD: begin
               prod_ff  <= diff_ff * frac_s;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               case (comp_ff)
                  COMP_X: begin
                     rsp_x_ff <= lerp_in;
                     comp_ff  <= COMP_Y;
                     state_ff <= S_DIFF;
                  end
                  COMP_Y: begin
                     rsp_y_ff <= lerp_in;
                     comp_ff  <= COMP_Z;
                     state_ff <= S_DIFF;
                  end
                  default: begin
                     rsp_z_ff       <= lerp_in;
                     rsp_time_ff    <= anim_ff;
                     rsp_wrapped_ff <= wrapped_ff;
                     rsp_valid_ff   <= 1'b1;
                     state_ff       <= S_IDLE;
                  end
               endcase
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample_x = rsp_x_ff;
   assign rsp_sample_y = rsp_y_ff;
   assign rsp_sample_z = rsp_z_ff;
   assign rsp_time_now = rsp_time_ff;
   assign rsp_wrapped  = rsp_wrapped_ff;

endmodule

// ===== rtl/kts_checker.sv =====
`include "keyframe_track_sampler_unit_macros.svh"

module kts_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_valid
);

   import kts_pkg::*;

   // A response strobe lasts exactly one cycle.
   `KTS_ASSERT_NEXT(a_rsp_single, !reset && rsp_valid, !rsp_valid, "response strobe held")

   // A response is shown only once the block is free again.
   `KTS_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "response while busy")

   // An accepted advance transaction occupies the block.
   `KTS_ASSERT_NEXT(a_adv_busy, !reset && start && !busy && req_func == FUNC_ADVANCE, busy,
      "advance not started")

   // A load completes at once and produces no response.
   `KTS_ASSERT_NEXT(a_load_quiet, !reset && start && !busy && req_func == FUNC_LOAD,
      !busy && !rsp_valid, "load occupied the block")

endmodule

bind keyframe_track_sampler_unit kts_checker u_kts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_func  (req_func),
   .rsp_valid (rsp_valid)
);
